@@ design/ptq_pkg.sv @@
// shared constants and word types of the priority task queue
`timescale 1ns / 1ps

package ptq_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CFG_W   = 5;
    localparam int LIM_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int TASK_W  = 16;
    localparam int PRIO_W  = 32;
    localparam int ENTRY_W = TASK_W + PRIO_W;
    localparam int OUT_CNT_W = 5;

    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    localparam logic OP_ADD      = 1'b0;
    localparam logic OP_COMPLETE = 1'b1;

    typedef struct packed {
        logic                     operation;
        logic [TASK_W-1:0]        task_handle;
        logic signed [PRIO_W-1:0] priority_req;
    } t_in_word;

    typedef struct packed {
        logic                     accepted;
        logic [TASK_W-1:0]        removed_task;
        logic signed [PRIO_W-1:0] removed_priority;
        logic [OUT_CNT_W-1:0]     entry_count;
        logic                     top_valid;
        logic [TASK_W-1:0]        top_task;
    } t_out_word;

    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   waddr;
        logic [ENTRY_W-1:0] wdata;
        logic [IDX_W-1:0]   raddr;
    } t_mem_req;

endpackage

@@ design/ptq_ram.sv @@
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module ptq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/ptq_ctrl.sv @@
// sequencer: add, and complete with compacting scan over the entry ram
`timescale 1ns / 1ps

module ptq_ctrl
    import ptq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_word           i_in_word,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output t_out_word          o_res_word,
    output t_mem_req           o_mem_req,
    input  logic [ENTRY_W-1:0] i_mem_rdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                   r_state;
    logic [CFG_W-1:0]         r_cap;
    logic [CNT_W-1:0]         r_count;
    logic [IDX_W-1:0]         r_top_idx;
    logic [TASK_W-1:0]        r_top_task;
    logic signed [PRIO_W-1:0] r_top_prio;
    t_out_word                r_res;
    logic [CNT_W-1:0]         r_ptr;
    logic                     r_rv;
    logic [IDX_W-1:0]         r_rd_q;
    logic                     r_best_valid;
    logic [TASK_W-1:0]        r_best_task;
    logic signed [PRIO_W-1:0] r_best_prio;
    logic [IDX_W-1:0]         r_best_pos;

    t_out_word                n_res;
    logic [LIM_W-1:0]         limit;
    logic                     accept;
    logic                     add_ok;
    logic                     new_is_top;
    logic                     start_scan;
    logic                     issue;
    logic [TASK_W-1:0]        rd_task;
    logic signed [PRIO_W-1:0] rd_prio;
    logic [IDX_W-1:0]         rd_pos;
    logic                     rd_keep;
    logic                     rd_better;
    logic [CNT_W-1:0]         count_dec;

    assign limit   = (LIM_W'(r_cap) > LIM_W'(DEPTH)) ? LIM_W'(DEPTH) : LIM_W'(r_cap);
    assign accept  = i_in_valid && (r_state == S_IDLE);
    assign add_ok  = LIM_W'(r_count) < limit;
    assign new_is_top = (r_count == '0) || (i_in_word.priority_req > r_top_prio);
    assign start_scan = (i_in_word.operation == OP_COMPLETE) && (r_count != '0);
    assign issue   = (r_state == S_SCAN) && (r_ptr < r_count);
    assign count_dec = r_count - CNT_W'(1);

    assign rd_task   = i_mem_rdata[ENTRY_W-1 -: TASK_W];
    assign rd_prio   = i_mem_rdata[PRIO_W-1:0];
    assign rd_keep   = r_rv && (r_rd_q != r_top_idx);
    assign rd_pos    = (r_rd_q < r_top_idx) ? r_rd_q : r_rd_q - IDX_W'(1);
    assign rd_better = !r_best_valid || (rd_prio > r_best_prio);

    // result word as known at acceptance; a complete fills in the rest after the scan
    always_comb begin
        n_res = '0;
        if (i_in_word.operation == OP_ADD) begin
            if (add_ok) begin
                n_res.accepted    = 1'b1;
                n_res.entry_count = OUT_CNT_W'(r_count + CNT_W'(1));
                n_res.top_valid   = 1'b1;
                n_res.top_task    = new_is_top ? i_in_word.task_handle : r_top_task;
            end else begin
                n_res.entry_count = OUT_CNT_W'(r_count);
                n_res.top_valid   = (r_count != '0);
                n_res.top_task    = (r_count != '0) ? r_top_task : '0;
            end
        end else if (r_count != '0) begin
            n_res.accepted         = 1'b1;
            n_res.removed_task     = r_top_task;
            n_res.removed_priority = r_top_prio;
        end
    end

    always_comb begin
        o_mem_req.raddr = r_ptr[IDX_W-1:0];
        o_mem_req.we    = 1'b0;
        o_mem_req.waddr = r_count[IDX_W-1:0];
        o_mem_req.wdata = {i_in_word.task_handle, i_in_word.priority_req};
        if (r_state == S_SCAN) begin
            // later entries move down one slot over the removed one
            o_mem_req.we    = r_rv && (r_rd_q > r_top_idx);
            o_mem_req.waddr = rd_pos;
            o_mem_req.wdata = i_mem_rdata;
        end else begin
            o_mem_req.we = accept && (i_in_word.operation == OP_ADD) && add_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cap        <= CAP_RESET;
            r_count      <= '0;
            r_rv         <= 1'b0;
            r_best_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= start_scan ? S_SCAN : S_DONE;
                        r_res   <= n_res;
                        if (i_in_word.operation == OP_ADD) begin
                            if (add_ok) begin
                                r_count <= r_count + CNT_W'(1);
                                if (new_is_top) begin
                                    r_top_idx  <= r_count[IDX_W-1:0];
                                    r_top_task <= i_in_word.task_handle;
                                    r_top_prio <= i_in_word.priority_req;
                                end
                            end
                        end else begin
                            if (r_count != '0) begin
                                r_ptr        <= '0;
                                r_rv         <= 1'b0;
                                r_best_valid <= 1'b0;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    r_rv   <= issue;
                    r_rd_q <= r_ptr[IDX_W-1:0];
                    if (issue) begin
                        r_ptr <= r_ptr + CNT_W'(1);
                    end
                    if (rd_keep && rd_better) begin
                        // strict compare in address order keeps the earliest on ties
                        r_best_valid <= 1'b1;
                        r_best_task  <= rd_task;
                        r_best_prio  <= rd_prio;
                        r_best_pos   <= rd_pos;
                    end
                    if (!issue && !r_rv) begin
                        r_state           <= S_DONE;
                        r_count           <= count_dec;
                        r_top_idx         <= r_best_pos;
                        r_top_task        <= r_best_task;
                        r_top_prio        <= r_best_prio;
                        r_res.entry_count <= OUT_CNT_W'(count_dec);
                        r_res.top_valid   <= r_best_valid;
                        r_res.top_task    <= r_best_valid ? r_best_task : '0;
                    end
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res_word  = r_res;

endmodule

@@ design/priority_task_queue.sv @@
// top level of the priority task queue: entry ram, sequencer, output register
`timescale 1ns / 1ps

// Unsorted array priority queue of 16-bit task handles with signed 32-bit
// priorities. An add word appends an entry at the end of the entry ram and
// updates the cached top entry. A complete word returns the cached top
// entry and then makes one pass over the ram, reading each held entry once
// (one read a cycle through the single read port, with registered read
// data), writing later entries one slot down and finding the new top. One
// word is worked on at a time; the output register lets the next word be
// accepted while a result still waits. capacity is taken from i_cfg_data
// on any cycle with i_cfg_we high and saturates at DEPTH.
// No clearing pass after reset: only slots that hold entries are read.

module priority_task_queue
    import ptq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_word         i_in_word,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_word        o_out_word
);

    // sequencer to ram request and result handoff
    t_mem_req           mem_req;
    logic [ENTRY_W-1:0] mem_rdata;
    logic               res_valid;
    logic               res_ready;
    t_out_word          res_word;

    // output register state
    logic               r_out_valid;
    t_out_word          r_out_word;

    // one ram holds {task, priority} per slot
    ptq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_raddr (mem_req.raddr),
        .o_rdata (mem_rdata)
    );

    ptq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res_word  (res_word),
        .o_mem_req   (mem_req),
        .i_mem_rdata (mem_rdata)
    );

    // output register takes a new word when empty or being drained
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (res_valid && res_ready) begin
                r_out_valid <= 1'b1;
                r_out_word  <= res_word;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

@@ design/ptq_checker.sv @@
// port-level checks of the priority task queue, bound to the top level
`timescale 1ns / 1ps

module ptq_checker
    import ptq_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input t_out_word        o_out_word
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.entry_count <= OUT_CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_top_vs_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.top_valid == (o_out_word.entry_count != '0))
        else $error("top valid disagrees with entry count");

    a_refused_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.accepted |->
            o_out_word.removed_task == '0 && o_out_word.removed_priority == '0)
        else $error("refused word reports a removed entry");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.top_valid |-> o_out_word.top_task == '0)
        else $error("empty queue reports a top task");

endmodule

bind priority_task_queue ptq_checker u_ptq_checker (.*);
